// ===== hw/rtl/rc6_block_cipher_assert.svh =====
// Assertion macros shared by the RC6 cipher RTL.
`ifndef RC6_BLOCK_CIPHER_ASSERT_SVH
`define RC6_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge of clk outside reset.
`define RC6_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("RC6 check failed");
// Next-cycle implication, checked on every rising edge of clk outside reset.
`define RC6_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("RC6 check failed");
`else
`define RC6_ASSERT_SAME(label, ante, cons)
`define RC6_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/rc6_pkg.sv =====
// Shared constants, types and command encodings for the RC6 block cipher.
package rc6_pkg;

    localparam int ROUND_COUNT   = 20;
    localparam int KEY_COUNT     = 2 * ROUND_COUNT + 4;
    localparam int KEY_AW        = $clog2(KEY_COUNT);
    localparam int PAIR_W        = KEY_AW - 1;
    localparam int MIX_COUNT     = 3 * KEY_COUNT;
    localparam int MIX_W         = $clog2(MIX_COUNT);
    localparam int RND_W         = $clog2(ROUND_COUNT + 1);
    localparam int KEY_WORDS     = 4;
    localparam int SCRATCH_WORDS = 8;
    localparam int SCRATCH_AW    = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [31:0] RC6_P32 = 32'hb7e15163;
    localparam logic [31:0] RC6_Q32 = 32'h9e3779b9;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE_SEL = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DECRYPT_MODE = 3'd5;

    // Key size codes.
    localparam logic [1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [1:0] KEY_SIZE_192 = 2'd1;

    typedef struct packed {
        logic [63:0] block_in_high;
        logic [63:0] block_in_low;
    } block_in_t;

    typedef struct packed {
        logic [63:0] block_out_high;
        logic [63:0] block_out_low;
    } block_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS_INIT,
        ST_KS_A,
        ST_KS_B,
        ST_CR_ADDR,
        ST_CR_PRE,
        ST_CR_ROUND,
        ST_CR_POST
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_KS_INIT,
        OP_MIX_A,
        OP_MIX_B,
        OP_ENC_PRE,
        OP_ENC_ROUND,
        OP_ENC_POST,
        OP_DEC_PRE,
        OP_DEC_ROUND,
        OP_DEC_POST
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic                    load;
        logic                    first_pass;
        logic [KEY_AW-1:0]       wr_addr;
        logic [KEY_AW-1:0]       rd_addr0;
        logic [KEY_AW-1:0]       rd_addr1;
        logic [SCRATCH_AW-1:0]   l_idx;
    } dp_cmd_t;

endpackage

// ===== hw/rtl/rc6_ctrl.sv =====
// Controller state machine for the RC6 cipher: key expansion and round sequencing.
`include "rc6_block_cipher_assert.svh"

module rc6_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_hit,
    input  logic              decrypt_mode,
    input  logic [1:0]        key_size_sel,
    output logic              busy,
    output logic              done,
    output rc6_pkg::dp_cmd_t  cmd
);

    localparam logic [rc6_pkg::PAIR_W-1:0] LAST_PAIR =
        rc6_pkg::PAIR_W'(rc6_pkg::KEY_COUNT / 2 - 1);
    localparam logic [rc6_pkg::RND_W-1:0] LAST_RND = rc6_pkg::RND_W'(rc6_pkg::ROUND_COUNT);
    localparam logic [rc6_pkg::RND_W-1:0] FIRST_RND = rc6_pkg::RND_W'(1);

    rc6_pkg::ctrl_state_t state_reg, state_next;
    logic valid_reg, valid_next;
    logic done_reg, done_next;
    logic [rc6_pkg::MIX_W-1:0] mix_reg, mix_next;
    logic [rc6_pkg::KEY_AW-1:0] key_idx_reg, key_idx_next;
    logic [rc6_pkg::SCRATCH_AW-1:0] l_idx_reg, l_idx_next;
    logic [rc6_pkg::RND_W-1:0] rnd_reg, rnd_next;

    logic [rc6_pkg::PAIR_W-1:0] pair;
    logic [rc6_pkg::SCRATCH_AW-1:0] l_last;
    logic round_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rc6_pkg::ST_IDLE;
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            mix_reg     <= '0;
            key_idx_reg <= '0;
            l_idx_reg   <= '0;
            rnd_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            mix_reg     <= mix_next;
            key_idx_reg <= key_idx_next;
            l_idx_reg   <= l_idx_next;
            rnd_reg     <= rnd_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        done_next    = 1'b0;
        mix_next     = mix_reg;
        key_idx_next = key_idx_reg;
        l_idx_next   = l_idx_reg;
        rnd_next     = rnd_reg;
        pair         = '0;

        case (key_size_sel)
            rc6_pkg::KEY_SIZE_128: l_last = 3'd3;
            rc6_pkg::KEY_SIZE_192: l_last = 3'd5;
            default:               l_last = 3'd7;
        endcase

        round_last = decrypt_mode ? (rnd_reg == FIRST_RND) : (rnd_reg == LAST_RND);

        cmd            = '0;
        cmd.op         = rc6_pkg::OP_IDLE;
        cmd.wr_addr    = key_idx_reg;
        cmd.l_idx      = l_idx_reg;
        cmd.first_pass = (mix_reg < rc6_pkg::MIX_W'(rc6_pkg::KEY_COUNT));

        case (state_reg)
            rc6_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = valid_reg ? rc6_pkg::ST_CR_ADDR : rc6_pkg::ST_KS_INIT;
                end
            end
            rc6_pkg::ST_KS_INIT:
            begin
                cmd.op       = rc6_pkg::OP_KS_INIT;
                mix_next     = '0;
                key_idx_next = '0;
                l_idx_next   = '0;
                state_next   = rc6_pkg::ST_KS_A;
            end
            rc6_pkg::ST_KS_A:
            begin
                cmd.op     = rc6_pkg::OP_MIX_A;
                state_next = rc6_pkg::ST_KS_B;
            end
            rc6_pkg::ST_KS_B:
            begin
                cmd.op = rc6_pkg::OP_MIX_B;
                if (key_idx_reg == rc6_pkg::KEY_AW'(rc6_pkg::KEY_COUNT - 1))
                begin
                    key_idx_next = '0;
                end
                else
                begin
                    key_idx_next = key_idx_reg + 1'b1;
                end
                l_idx_next = (l_idx_reg == l_last) ? '0 : l_idx_reg + 1'b1;
                mix_next   = mix_reg + 1'b1;
                if (mix_reg == rc6_pkg::MIX_W'(rc6_pkg::MIX_COUNT - 1))
                begin
                    valid_next = 1'b1;
                    state_next = rc6_pkg::ST_CR_ADDR;
                end
                else
                begin
                    state_next = rc6_pkg::ST_KS_A;
                end
            end
            rc6_pkg::ST_CR_ADDR:
            begin
                pair       = decrypt_mode ? LAST_PAIR : '0;
                state_next = rc6_pkg::ST_CR_PRE;
            end
            rc6_pkg::ST_CR_PRE:
            begin
                cmd.op     = decrypt_mode ? rc6_pkg::OP_DEC_PRE : rc6_pkg::OP_ENC_PRE;
                rnd_next   = decrypt_mode ? LAST_RND : FIRST_RND;
                pair       = rc6_pkg::PAIR_W'(rnd_next);
                state_next = rc6_pkg::ST_CR_ROUND;
            end
            rc6_pkg::ST_CR_ROUND:
            begin
                cmd.op = decrypt_mode ? rc6_pkg::OP_DEC_ROUND : rc6_pkg::OP_ENC_ROUND;
                if (round_last)
                begin
                    pair       = decrypt_mode ? '0 : LAST_PAIR;
                    state_next = rc6_pkg::ST_CR_POST;
                end
                else
                begin
                    rnd_next = decrypt_mode ? rnd_reg - 1'b1 : rnd_reg + 1'b1;
                    pair     = rc6_pkg::PAIR_W'(rnd_next);
                end
            end
            rc6_pkg::ST_CR_POST:
            begin
                cmd.op     = decrypt_mode ? rc6_pkg::OP_DEC_POST : rc6_pkg::OP_ENC_POST;
                done_next  = 1'b1;
                state_next = rc6_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rc6_pkg::ST_IDLE;
            end
        endcase

        cmd.rd_addr0 = {pair, 1'b0};
        cmd.rd_addr1 = {pair, 1'b1};
        // During the second mixing phase, prefetch the round key for the next step.
        if (state_reg == rc6_pkg::ST_KS_B)
        begin
            cmd.rd_addr0 = key_idx_next;
        end

        // A write to a defined register invalidates the round keys.
        if (cfg_hit)
        begin
            valid_next = 1'b0;
        end
    end

    assign busy = (state_reg != rc6_pkg::ST_IDLE);
    assign done = done_reg;

    `RC6_ASSERT_SAME(a_done_in_idle, done_reg, state_reg == rc6_pkg::ST_IDLE)
    `RC6_ASSERT_NEXT(a_post_gives_done, state_reg == rc6_pkg::ST_CR_POST, done_reg)
    `RC6_ASSERT_NEXT(a_cfg_invalidates, cfg_hit, !valid_reg)
    `RC6_ASSERT_NEXT(a_valid_skips_keys,
        state_reg == rc6_pkg::ST_IDLE && start && valid_reg && !cfg_hit,
        state_reg == rc6_pkg::ST_CR_ADDR)
    `RC6_ASSERT_SAME(a_round_in_range, state_reg == rc6_pkg::ST_CR_ROUND,
        rnd_reg >= FIRST_RND && rnd_reg <= LAST_RND)

endmodule

// ===== hw/rtl/rc6_datapath.sv =====
// Datapath for the RC6 cipher: round key memory, key mixing unit and round unit.
module rc6_datapath (
    input  logic                    clk,
    input  logic [3:0][63:0]        key_words,
    input  rc6_pkg::dp_cmd_t        cmd,
    input  rc6_pkg::block_in_t      block_in,
    output rc6_pkg::block_out_t     block_out
);

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} >> n;
        return w[31:0];
    endfunction

    // x * (2x + 1) mod 2^32, rotated left by five.
    function automatic logic [31:0] mix_f(input logic [31:0] x);
        logic [31:0] p;
        p = x * {x[30:0], 1'b1};
        return rotl32(p, 5'd5);
    endfunction

    logic [31:0] rk_mem [rc6_pkg::KEY_COUNT];
    logic [31:0] scratch_reg [rc6_pkg::SCRATCH_WORDS];
    logic [31:0] rd0_reg, rd1_reg;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] ka_reg, ka_next, kb_reg, kb_next, init_reg, init_next;

    logic [31:0] mul_x, mul_y, t_val, u_val;
    logic [31:0] s_val, sum_ab, mix_a, mix_b;
    logic        dec_round;

    always_comb
    begin
        dec_round = (cmd.op == rc6_pkg::OP_DEC_ROUND);
        mul_x     = dec_round ? a_reg : b_reg;
        mul_y     = dec_round ? c_reg : d_reg;
        t_val     = mix_f(mul_x);
        u_val     = mix_f(mul_y);

        s_val  = cmd.first_pass ? init_reg : rd0_reg;
        sum_ab = ka_reg + kb_reg;
        mix_a  = rotl32(s_val + sum_ab, 5'd3);
        mix_b  = rotl32(scratch_reg[cmd.l_idx] + sum_ab, sum_ab[4:0]);

        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        ka_next   = ka_reg;
        kb_next   = kb_reg;
        init_next = init_reg;

        case (cmd.op)
            rc6_pkg::OP_KS_INIT:
            begin
                ka_next   = '0;
                kb_next   = '0;
                init_next = rc6_pkg::RC6_P32;
            end
            rc6_pkg::OP_MIX_A:
            begin
                ka_next = mix_a;
            end
            rc6_pkg::OP_MIX_B:
            begin
                kb_next   = mix_b;
                init_next = init_reg + rc6_pkg::RC6_Q32;
            end
            rc6_pkg::OP_ENC_PRE:
            begin
                b_next = b_reg + rd0_reg;
                d_next = d_reg + rd1_reg;
            end
            rc6_pkg::OP_ENC_ROUND:
            begin
                a_next = b_reg;
                b_next = rotl32(c_reg ^ u_val, t_val[4:0]) + rd1_reg;
                c_next = d_reg;
                d_next = rotl32(a_reg ^ t_val, u_val[4:0]) + rd0_reg;
            end
            rc6_pkg::OP_ENC_POST:
            begin
                a_next = a_reg + rd0_reg;
                c_next = c_reg + rd1_reg;
            end
            rc6_pkg::OP_DEC_PRE:
            begin
                a_next = a_reg - rd0_reg;
                c_next = c_reg - rd1_reg;
            end
            rc6_pkg::OP_DEC_ROUND:
            begin
                // Words are rotated back first: new A..D come from D, A, B, C.
                a_next = rotr32(d_reg - rd0_reg, u_val[4:0]) ^ t_val;
                b_next = a_reg;
                c_next = rotr32(b_reg - rd1_reg, t_val[4:0]) ^ u_val;
                d_next = c_reg;
            end
            rc6_pkg::OP_DEC_POST:
            begin
                b_next = b_reg - rd0_reg;
                d_next = d_reg - rd1_reg;
            end
            default:
            begin
            end
        endcase

        if (cmd.load)
        begin
            a_next = block_in.block_in_low[31:0];
            b_next = block_in.block_in_low[63:32];
            c_next = block_in.block_in_high[31:0];
            d_next = block_in.block_in_high[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        ka_reg   <= ka_next;
        kb_reg   <= kb_next;
        init_reg <= init_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == rc6_pkg::OP_KS_INIT)
        begin
            for (int w = 0; w < rc6_pkg::SCRATCH_WORDS; w++)
            begin
                scratch_reg[w] <= key_words[w / 2][(w % 2) * 32 +: 32];
            end
        end
        else if (cmd.op == rc6_pkg::OP_MIX_B)
        begin
            scratch_reg[cmd.l_idx] <= mix_b;
        end
    end

    // Round key memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.op == rc6_pkg::OP_MIX_A)
        begin
            rk_mem[cmd.wr_addr] <= mix_a;
        end
        rd0_reg <= rk_mem[cmd.rd_addr0];
        rd1_reg <= rk_mem[cmd.rd_addr1];
    end

    assign block_out.block_out_low  = {b_reg, a_reg};
    assign block_out.block_out_high = {d_reg, c_reg};

endmodule

// ===== hw/rtl/rc6_block_cipher.sv =====
// Top level of the RC6-32/20 ECB block cipher with its configuration registers.
//
// A 128-bit block is taken at a rising edge where start is high and busy is low, and
// its encrypted or decrypted image appears on block_out for exactly one cycle, marked
// by done; the receiver cannot stall the block, so it must capture the result in that
// cycle. With a valid key schedule a request runs through these steps from acceptance
// to done: the first round key read, the input whitening, twenty rounds at one round
// per clock through a single round unit with two 32x32 multipliers, the output
// whitening, and the step in which done is high and the result is taken. The next
// request may be accepted in the cycle that done is high; until then a new block is
// not taken. After reset or after any write to a defined register, the first request
// also runs the key expansion: one setup step and 132 mixing steps, each a round key
// update followed by the key word update that depends on the new round key.
// Registers must be written through wr_en, wr_index and wr_data only while the block is
// idle, which the block itself does not enforce; indexes beyond decrypt_mode are ignored.
module rc6_block_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rc6_pkg::block_in_t                  block_in,
    output logic                                done,
    output rc6_pkg::block_out_t                 block_out,
    input  logic                                wr_en,
    input  logic [rc6_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [rc6_pkg::CFG_DATA_W-1:0]      wr_data
);

    logic [3:0][63:0] key_word_reg;
    logic [1:0]       key_size_sel_reg;
    logic             decrypt_mode_reg;
    logic             cfg_hit;

    rc6_pkg::dp_cmd_t cmd;

    // Any write to a defined register forces the key schedule to be rebuilt.
    assign cfg_hit = wr_en && (wr_index <= rc6_pkg::REG_DECRYPT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word_reg     <= '0;
            key_size_sel_reg <= rc6_pkg::KEY_SIZE_128;
            decrypt_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rc6_pkg::REG_KEY_WORD0:    key_word_reg[0]  <= wr_data;
                rc6_pkg::REG_KEY_WORD1:    key_word_reg[1]  <= wr_data;
                rc6_pkg::REG_KEY_WORD2:    key_word_reg[2]  <= wr_data;
                rc6_pkg::REG_KEY_WORD3:    key_word_reg[3]  <= wr_data;
                rc6_pkg::REG_KEY_SIZE_SEL: key_size_sel_reg <= wr_data[1:0];
                rc6_pkg::REG_DECRYPT_MODE: decrypt_mode_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // The controller sequences key expansion and the rounds; the datapath does the math.
    rc6_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cfg_hit      (cfg_hit),
        .decrypt_mode (decrypt_mode_reg),
        .key_size_sel (key_size_sel_reg),
        .busy         (busy),
        .done         (done),
        .cmd          (cmd)
    );

    rc6_datapath u_datapath (
        .clk       (clk),
        .key_words (key_word_reg),
        .cmd       (cmd),
        .block_in  (block_in),
        .block_out (block_out)
    );

endmodule

// ===== test/rc6_block_cipher_tb.sv =====
// Self-checking testbench for the RC6-32/20 block cipher, with its own cipher predictor.
`timescale 1ns / 100ps

module rc6_block_cipher_tb;
    import rc6_pkg::*;

    // Clock and run shaping.
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 4;
    // The slowest correct request is a key expansion plus the rounds, and the longest
    // sender gap is MAX_GAP; the limit is several times their sum.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_GAP        = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 30;
    localparam int PHASE_ITEMS    = 550;
    localparam int MAX_REPORTS    = 40;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] KEY_SIZE_256  = 2'd2;
    localparam logic [1:0] KEY_SIZE_RSVD = 2'd3;
    localparam logic       MODE_ENCRYPT  = 1'b0;
    localparam logic       MODE_DECRYPT  = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // The published all-zero test vector: zero 128-bit key, zero plaintext.
    localparam logic [127:0] ZERO_KEY_CIPHERTEXT =
        128'h1ea44898_4edf29c1_78f7b156_36a5c38f;

    localparam bit ROW_WRITE = 1'b1;
    localparam bit ROW_BLOCK = 1'b0;

    // One line of the directed stimulus: either a register write or a block request.
    // Where the answer is known by heart it is typed in and replaces the prediction.
    typedef struct {
        bit                       is_write;
        logic [CFG_INDEX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]    data;
        block_in_t                blk;
        bit                       known;
        block_out_t               answer;
    } stim_row_t;

    localparam int NUM_ROWS = 28;

    stim_row_t stim_rows [NUM_ROWS] = '{
        // Reset key, zero plaintext.
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '0, 1'b1, ZERO_KEY_CIPHERTEXT},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '1, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, 128'h55555555_55555555_aaaaaaaa_aaaaaaaa, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, 128'h80000000_00000001_00000001_80000000, 1'b0, '0},
        // Decrypting the known ciphertext must give back the zero block.
        '{ROW_WRITE, REG_DECRYPT_MODE, 64'(MODE_DECRYPT), '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, ZERO_KEY_CIPHERTEXT, 1'b1, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '1, 1'b0, '0},
        // A 192-bit key with all-ones low words.
        '{ROW_WRITE, REG_KEY_WORD0, '1, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD1, '1, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD2, 64'h01234567_89abcdef, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD3, 64'hfedcba98_76543210, '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_SIZE_SEL, 64'(KEY_SIZE_192), '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, 128'hdeadbeef_01234567_89abcdef_cafef00d, 1'b0, '0},
        '{ROW_WRITE, REG_DECRYPT_MODE, 64'(MODE_ENCRYPT), '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, 128'hdeadbeef_01234567_89abcdef_cafef00d, 1'b0, '0},
        // Full 256-bit key, then the reserved size code, which also means 256 bits.
        '{ROW_WRITE, REG_KEY_SIZE_SEL, 64'(KEY_SIZE_256), '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '1, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_SIZE_SEL, 64'(KEY_SIZE_RSVD), '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '0, 1'b0, '0},
        // Writes past the last register are dropped and keep the schedule.
        '{ROW_WRITE, REG_SPARE_LO, '1, '0, 1'b0, '0},
        '{ROW_WRITE, REG_SPARE_HI, 64'h5a5a5a5a_a5a5a5a5, '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, 128'h00000000_ffffffff_ffffffff_00000000, 1'b0, '0},
        // Back to a 128-bit key with a zero low word.
        '{ROW_WRITE, REG_KEY_SIZE_SEL, 64'(KEY_SIZE_128), '0, 1'b0, '0},
        '{ROW_WRITE, REG_KEY_WORD0, '0, '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, '1, 1'b0, '0},
        '{ROW_WRITE, REG_DECRYPT_MODE, 64'(MODE_DECRYPT), '0, 1'b0, '0},
        '{ROW_BLOCK, REG_KEY_WORD0, '0, 128'h13579bdf_2468ace0_fdb97531_0eca8642, 1'b0, '0}
    };

    // Block ports. Every input has a known value from time zero.
    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    start    = 1'b0;
    logic                    busy;
    block_in_t               block_in = '0;
    logic                    done;
    block_out_t              block_out;
    logic                    wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0]   wr_data  = '0;

    rc6_block_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: a private copy of the registers and the round key table.
    // The schedule is rebuilt lazily, on the first request after any write to a defined
    // register, exactly as the hardware does it.
    bit [63:0] model_key [KEY_WORDS];
    bit [1:0]  model_key_size;
    bit        model_decrypt;
    bit        model_sched_ok;
    bit [31:0] model_rk [KEY_COUNT];

    // Results still owed by the block, oldest first, and typed-in answers waiting
    // for the request that they belong to.
    block_out_t pending_blocks [$];
    block_out_t known_answers [$];

    int mismatches       = 0;
    int results_checked  = 0;
    int blocks_encrypted = 0;
    int blocks_decrypted = 0;
    int schedules_built [4];
    int stall_cycles     = 0;

    function automatic bit [31:0] rotl(bit [31:0] x, bit [31:0] n);
        bit [4:0] amt;
        amt = n[4:0];
        return (amt == 5'd0) ? x : ((x << amt) | (x >> (32 - amt)));
    endfunction

    function automatic bit [31:0] rotr(bit [31:0] x, bit [31:0] n);
        bit [4:0] amt;
        amt = n[4:0];
        return (amt == 5'd0) ? x : ((x >> amt) | (x << (32 - amt)));
    endfunction

    // Standard RC6 key expansion: the magic-constant ramp, then three passes of
    // mixing over the 44 round keys and the key words of the selected length.
    function automatic void expand_round_keys();
        bit [31:0] scratch [SCRATCH_WORDS];
        bit [31:0] a;
        bit [31:0] b;
        int        words;
        int        ki;
        int        li;
        int        w;
        case (model_key_size)
            KEY_SIZE_128: words = 4;
            KEY_SIZE_192: words = 6;
            default:      words = 8;
        endcase
        for (w = 0; w < SCRATCH_WORDS; w++)
            scratch[w] = model_key[w / 2][32 * (w % 2) +: 32];
        model_rk[0] = RC6_P32;
        for (w = 1; w < KEY_COUNT; w++)
            model_rk[w] = model_rk[w - 1] + RC6_Q32;
        a  = '0;
        b  = '0;
        ki = 0;
        li = 0;
        for (w = 0; w < MIX_COUNT; w++)
        begin
            a            = rotl(model_rk[ki] + a + b, 3);
            model_rk[ki] = a;
            b            = rotl(scratch[li] + a + b, a + b);
            scratch[li]  = b;
            ki           = (ki + 1 == KEY_COUNT) ? 0 : ki + 1;
            li           = (li + 1 == words) ? 0 : li + 1;
        end
        model_sched_ok = 1'b1;
        schedules_built[model_key_size]++;
    endfunction

    // One block through twenty rounds in the direction that the register selects.
    function automatic block_out_t cipher_block(block_in_t blk);
        bit [31:0]  a;
        bit [31:0]  b;
        bit [31:0]  c;
        bit [31:0]  d;
        bit [31:0]  t;
        bit [31:0]  u;
        bit [31:0]  x;
        block_out_t res;
        int         r;
        {b, a} = blk.block_in_low;
        {d, c} = blk.block_in_high;
        if (model_decrypt == MODE_ENCRYPT)
        begin
            b = b + model_rk[0];
            d = d + model_rk[1];
            for (r = 1; r <= ROUND_COUNT; r++)
            begin
                t = rotl(b * (2 * b + 1), 5);
                u = rotl(d * (2 * d + 1), 5);
                a = rotl(a ^ t, u) + model_rk[2 * r];
                c = rotl(c ^ u, t) + model_rk[2 * r + 1];
                x = a;
                a = b;
                b = c;
                c = d;
                d = x;
            end
            a = a + model_rk[2 * ROUND_COUNT + 2];
            c = c + model_rk[2 * ROUND_COUNT + 3];
        end
        else
        begin
            c = c - model_rk[2 * ROUND_COUNT + 3];
            a = a - model_rk[2 * ROUND_COUNT + 2];
            for (r = ROUND_COUNT; r >= 1; r--)
            begin
                x = d;
                d = c;
                c = b;
                b = a;
                a = x;
                u = rotl(d * (2 * d + 1), 5);
                t = rotl(b * (2 * b + 1), 5);
                c = rotr(c - model_rk[2 * r + 1], t) ^ u;
                a = rotr(a - model_rk[2 * r], u) ^ t;
            end
            d = d - model_rk[1];
            b = b - model_rk[0];
        end
        res.block_out_low  = {b, a};
        res.block_out_high = {d, c};
        return res;
    endfunction

    // Mirror of a register write. Indexes past the list change nothing, so the
    // schedule stays valid for them.
    function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] index,
                                            logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3:
            begin
                model_key[index[1:0]] = data;
                model_sched_ok        = 1'b0;
            end
            REG_KEY_SIZE_SEL:
            begin
                model_key_size = data[1:0];
                model_sched_ok = 1'b0;
            end
            REG_DECRYPT_MODE:
            begin
                model_decrypt  = data[0];
                model_sched_ok = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Mostly random words, with a share of all-zero, all-one, one-hot and one-cold
    // blocks so that the corners of the datapath come up often.
    function automatic block_in_t random_block();
        block_in_t blk;
        blk = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(15))
            0:       blk = '0;
            1:       blk = '1;
            2:       blk = 128'b1 << $urandom_range(127);
            3:       blk = ~(128'b1 << $urandom_range(127));
            default: ;
        endcase
        return blk;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    // Drops start and waits until every owed result has come back, then a few quiet
    // cycles, so that register writes only ever land on an idle block.
    task automatic settle_block();
        @(negedge clk);
        start    <= 1'b0;
        block_in <= random_block();
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // Presents one request after a random gap and holds it until the block takes it.
    // While start is low the data bus carries noise. start stays high on return, so
    // back-to-back requests never lower and raise it in the same step.
    task automatic issue_block(block_in_t blk, int idle_pct, bit known, block_out_t answer);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            @(negedge clk);
            start    <= 1'b0;
            block_in <= random_block();
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        if (known)
            known_answers.push_back(answer);
        start    <= 1'b1;
        block_in <= blk;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // New key and direction for each phase and segment of random traffic. The extreme form uses
    // all-zero or all-one key words with the shortest or the reserved key size.
    task automatic load_random_settings(bit extremes);
        logic [CFG_DATA_W-1:0] val;
        int                    k;
        settle_block();
        for (k = 0; k < KEY_WORDS; k++)
        begin
            if (extremes || $urandom_range(9) < 7)
            begin
                case ($urandom_range(7))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = {$urandom, $urandom};
                endcase
                if (extremes)
                    val = $urandom_range(1) ? '1 : '0;
                write_reg(CFG_INDEX_W'(REG_KEY_WORD0 + k), val);
            end
        end
        if (extremes)
            write_reg(REG_KEY_SIZE_SEL, $urandom_range(1) ? 64'(KEY_SIZE_RSVD) : 64'(KEY_SIZE_128));
        else
            write_reg(REG_KEY_SIZE_SEL, 64'($urandom_range(3)));
        write_reg(REG_DECRYPT_MODE, $urandom_range(1) ? 64'(MODE_DECRYPT) : 64'(MODE_ENCRYPT));
        if ($urandom_range(7) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
    endtask

    // Everything is observed at the rising edge, where the block samples too: register
    // writes update the predictor, accepted requests get their prediction queued, and
    // each done pulse is compared with the oldest prediction.
    always @(posedge clk)
    begin
        block_out_t want;
        block_out_t got;
        bit         handshake;
        if (rst_n)
        begin
            handshake = 1'b0;
            if (wr_en === 1'b1)
            begin
                apply_reg_write(wr_index, wr_data);
                handshake = 1'b1;
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                if (!model_sched_ok)
                    expand_round_keys();
                want = cipher_block(block_in);
                if (model_decrypt == MODE_DECRYPT)
                    blocks_decrypted++;
                else
                    blocks_encrypted++;
                if (known_answers.size() != 0)
                    want = known_answers.pop_front();
                pending_blocks.push_back(want);
                handshake = 1'b1;
            end
            if (done === 1'b1)
            begin
                got       = block_out;
                handshake = 1'b1;
                if (pending_blocks.size() == 0)
                    report_mismatch($sformatf("result %h with no request outstanding", got));
                else
                begin
                    want = pending_blocks.pop_front();
                    results_checked++;
                    if (got.block_out_low !== want.block_out_low)
                        report_mismatch($sformatf("block_out_low %h, expected %h",
                                                  got.block_out_low, want.block_out_low));
                    if (got.block_out_high !== want.block_out_high)
                        report_mismatch($sformatf("block_out_high %h, expected %h",
                                                  got.block_out_high, want.block_out_high));
                end
            end
            // Watchdog: a long run of cycles with no handshake of any kind means the
            // block has hung.
            stall_cycles = handshake ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("No handshake for %0d cycles, giving up.", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int row;
        int phase;
        int left;
        int seg;
        int idle_pct;

        // Single reset at the start of the run, released on a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: each write row waits for an idle block first.
        for (row = 0; row < NUM_ROWS; row++)
        begin
            if (stim_rows[row].is_write)
            begin
                settle_block();
                write_reg(stim_rows[row].index, stim_rows[row].data);
            end
            else
                issue_block(stim_rows[row].blk, 35, stim_rows[row].known,
                            stim_rows[row].answer);
        end

        // Random part in three phases: the sender idles often, then almost always,
        // then never. Each phase is cut into segments with a fresh key and direction,
        // and now and then the sender holds off until the block has drained.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       idle_pct = 35;
                1:       idle_pct = 87;
                default: idle_pct = 0;
            endcase
            left = PHASE_ITEMS;
            load_random_settings(1'b1);
            while (left > 0)
            begin
                seg = $urandom_range(20, 80);
                while (seg > 0 && left > 0)
                begin
                    if ($urandom_range(63) == 0)
                        settle_block();
                    issue_block(random_block(), idle_pct, 1'b0, '0);
                    seg--;
                    left--;
                end
                if (left > 0)
                    load_random_settings(1'b0);
            end
        end

        // Let the last results drain, then allow for anything stray.
        settle_block();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_blocks.size() != 0)
            report_mismatch($sformatf("%0d requests never returned a result",
                                      pending_blocks.size()));

        $display("Checked %0d results from %0d encrypt and %0d decrypt requests.",
                 results_checked, blocks_encrypted, blocks_decrypted);
        $display("Key expansions: %0d at 128 bits, %0d at 192, %0d at 256, %0d reserved size.",
                 schedules_built[0], schedules_built[1], schedules_built[2],
                 schedules_built[3]);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== rc6_block_cipher.f =====
+incdir+hw/rtl
hw/rtl/rc6_pkg.sv
hw/rtl/rc6_ctrl.sv
hw/rtl/rc6_datapath.sv
hw/rtl/rc6_block_cipher.sv
test/rc6_block_cipher_tb.sv
